/* design/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// Barometric pressure compensation package
// Register indexes and fixed constants of the integer compensation.
// ----------------------------------------------------------------------------
`default_nettype none

package bpc_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CAL_A = 2'd0,
    CFG_CAL_B = 2'd1,
    CFG_CAL_C = 2'd2,
    CFG_OSS   = 2'd3
  } cfg_reg_t;

  // Temperature offset subtracted from B5 to form B6.
  localparam logic signed [27:0] B6_OFFSET = 28'sd4000;
  // Rounding term added before the final temperature shift.
  localparam logic signed [28:0] T_ROUND = 29'sd8;
  // Bias added to X3 before the B4 product.
  localparam logic [31:0] B4_BIAS = 32'd32768;
  // Scale applied to the pressure difference, shifted by oversampling.
  localparam logic [15:0] B7_SCALE = 16'd50000;
  // Pressure correction coefficients.
  localparam logic [11:0]        P_SQ_COEF  = 12'd3038;
  localparam logic signed [13:0] P_LIN_COEF = -14'sd7357;
  localparam logic signed [45:0] P_OFFSET   = 46'sd3791;

  // Output limits.
  localparam logic signed [24:0] TEMP_MAX = 25'sd32767;
  localparam logic signed [24:0] TEMP_MIN = -25'sd32768;
  localparam logic signed [45:0] PRES_MAX = 46'sd262143;

endpackage

`default_nettype wire

/* design/bpc_divider.sv */
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with a side word
// carried alongside each dividend.
// ----------------------------------------------------------------------------
`default_nettype none

module bpc_divider #(
  parameter int NW = 32,
  parameter int DW = 17,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  input  wire logic [SW-1:0] in_side,
  output logic               out_valid,
  output logic [NW-1:0]      quotient,
  output logic [SW-1:0]      out_side
);

  // Stage registers: partial remainder, shifting dividend/quotient word.
  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] word_q [NW];
  logic [DW-1:0] dsr_q  [NW];
  logic [SW-1:0] side_q [NW];
  logic [NW-1:0] vld_q;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [NW-1:0] w_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic          v_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign w_in = dividend;
      assign d_in = divisor;
      assign s_in = in_side;
      assign v_in = in_valid;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign w_in = word_q[k-1];
      assign d_in = dsr_q[k-1];
      assign s_in = side_q[k-1];
      assign v_in = vld_q[k-1];
    end

    // Bring down the next dividend bit and try the subtraction.
    assign trial = {r_in, w_in[NW-1]};
    assign diff  = trial - {1'b0, d_in};
    assign ge    = (trial >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
        word_q[k] <= {w_in[NW-2:0], ge};
        dsr_q[k]  <= d_in;
        side_q[k] <= s_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= v_in;
      end
    end
  end

  assign out_valid = vld_q[NW-1];
  assign quotient  = word_q[NW-1];
  assign out_side  = side_q[NW-1];

endmodule

`default_nettype wire

/* design/barometric_pressure_compensation.sv */
// ----------------------------------------------------------------------------
// Barometric pressure compensation
// Integer temperature and pressure compensation of a digital barometer.
// ----------------------------------------------------------------------------
// Each input word (raw temperature and raw pressure counts) yields one result
// word: temperature in tenths of a degree, pressure in pascals and a fault
// flag that is set, with both results zero, when either divisor is zero. The
// pipeline accepts one word per clock and is built of two entry stages, a
// 27-stage temperature divider, six coefficient stages, a 32-stage pressure
// divider and three correction stages, the last of which is the output
// register. The whole pipeline holds when a result waits at the output. The
// user must write calibration registers through the configuration port only
// while no word is in flight (not enforced by the block); they reset to zero.
`default_nettype none

module barometric_pressure_compensation (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [15:0]        raw_temperature,
  input  wire logic [18:0]        raw_pressure,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      temperature_tenths,
  output logic [17:0]             pressure_pa,
  output logic                    fault
);

  localparam int TD_SIDE_W = 39;
  localparam int PD_SIDE_W = 18;

  // --------------------------------------------------------------------------
  // Configuration registers.
  logic [63:0] cal_word_a;
  logic [63:0] cal_word_b;
  logic [31:0] cal_word_c;
  logic [1:0]  oversampling;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_word_a   <= '0;
      cal_word_b   <= '0;
      cal_word_c   <= '0;
      oversampling <= '0;
    end else if (cfg_valid) begin
      unique case (bpc_pkg::cfg_reg_t'(cfg_index))
        bpc_pkg::CFG_CAL_A: cal_word_a   <= cfg_data;
        bpc_pkg::CFG_CAL_B: cal_word_b   <= cfg_data;
        bpc_pkg::CFG_CAL_C: cal_word_c   <= cfg_data[31:0];
        bpc_pkg::CFG_OSS:   oversampling <= cfg_data[1:0];
        default:            cal_word_a   <= cal_word_a;
      endcase
    end
  end

  // Coefficient fields.
  logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
  logic [15:0]        ac4, ac5, ac6;

  assign ac1 = $signed(cal_word_a[15:0]);
  assign ac2 = $signed(cal_word_a[31:16]);
  assign ac3 = $signed(cal_word_a[47:32]);
  assign ac4 = cal_word_a[63:48];
  assign ac5 = cal_word_b[15:0];
  assign ac6 = cal_word_b[31:16];
  assign b1  = $signed(cal_word_b[47:32]);
  assign b2  = $signed(cal_word_b[63:48]);
  assign mc  = $signed(cal_word_c[15:0]);
  assign md  = $signed(cal_word_c[31:16]);

  // The whole pipeline advances unless a result waits at the output.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // --------------------------------------------------------------------------
  // Stage 1: (UT - AC6) * AC5.
  logic signed [17:0] s1c_d;
  logic signed [34:0] s1c_prod;
  logic signed [34:0] s1_prod;
  logic [18:0]        s1_up;
  logic               s1_valid;

  assign s1c_d    = $signed({2'b00, raw_temperature}) - $signed({2'b00, ac6});
  assign s1c_prod = s1c_d * $signed({1'b0, ac5});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod <= s1c_prod;
      s1_up   <= raw_pressure;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: X1, divisor X1 + MD and magnitudes for the divider.
  logic signed [19:0] s2c_x1;
  logic signed [19:0] s2c_den;
  logic [19:0]        s2c_den_mag;
  logic [15:0]        s2c_mc_mag;
  logic signed [17:0] s2_x1;
  logic [26:0]        s2_num;
  logic [17:0]        s2_den;
  logic               s2_neg;
  logic               s2_dz;
  logic [18:0]        s2_up;
  logic               s2_valid;

  assign s2c_x1      = $signed(s1_prod[34:15]);
  assign s2c_den     = s2c_x1 + 20'($signed(md));
  assign s2c_den_mag = s2c_den[19] ? 20'(-s2c_den) : 20'(s2c_den);
  assign s2c_mc_mag  = mc[15] ? 16'(-mc) : 16'(mc);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x1  <= s2c_x1[17:0];
      s2_num <= {s2c_mc_mag, 11'd0};
      s2_den <= s2c_den_mag[17:0];
      s2_neg <= mc[15] ^ s2c_den[19];
      s2_dz  <= (s2c_den == 20'sd0);
      s2_up  <= s1_up;
    end
  end

  // --------------------------------------------------------------------------
  // Temperature divider: |MC * 2048| / |X1 + MD|.
  logic                 td_valid;
  logic [26:0]          td_q;
  logic [TD_SIDE_W-1:0] td_side;

  bpc_divider #(
    .NW (27),
    .DW (18),
    .SW (TD_SIDE_W)
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .dividend  (s2_num),
    .divisor   (s2_den),
    .in_side   ({s2_x1, s2_neg, s2_dz, s2_up}),
    .out_valid (td_valid),
    .quotient  (td_q),
    .out_side  (td_side)
  );

  // --------------------------------------------------------------------------
  // Stage 3: X2 with sign, B5 and B6.
  logic signed [27:0] s3c_q;
  logic signed [27:0] s3c_x2;
  logic signed [27:0] s3c_b5;
  logic signed [17:0] s3c_x1;
  logic signed [27:0] s3_b5;
  logic signed [27:0] s3_b6;
  logic               s3_dz;
  logic [18:0]        s3_up;
  logic               s3_valid;

  assign s3c_x1 = $signed(td_side[38:21]);
  assign s3c_q  = $signed({1'b0, td_q});
  assign s3c_x2 = td_side[20] ? -s3c_q : s3c_q;
  assign s3c_b5 = s3c_x2 + 28'(s3c_x1);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_b5 <= s3c_b5;
      s3_b6 <= s3c_b5 - bpc_pkg::B6_OFFSET;
      s3_dz <= td_side[19];
      s3_up <= td_side[18:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: temperature result, B6 squared, AC2 * B6 and AC3 * B6.
  logic signed [28:0] s4c_tr;
  logic signed [24:0] s4c_t;
  logic signed [15:0] s4c_tsat;
  logic signed [55:0] s4c_sq;
  logic signed [43:0] s4c_m2;
  logic signed [43:0] s4c_m3;
  logic signed [15:0] s4_t;
  logic [53:0]        s4_sqf;
  logic signed [43:0] s4_m2;
  logic signed [43:0] s4_m3;
  logic               s4_dz;
  logic [18:0]        s4_up;
  logic               s4_valid;

  assign s4c_tr = 29'(s3_b5) + bpc_pkg::T_ROUND;
  assign s4c_t  = $signed(s4c_tr[28:4]);
  assign s4c_sq = s3_b6 * s3_b6;
  assign s4c_m2 = ac2 * s3_b6;
  assign s4c_m3 = ac3 * s3_b6;

  always_comb begin
    if (s4c_t > bpc_pkg::TEMP_MAX) begin
      s4c_tsat = 16'sh7fff;
    end else if (s4c_t < bpc_pkg::TEMP_MIN) begin
      s4c_tsat = 16'sh8000;
    end else begin
      s4c_tsat = s4c_t[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_t   <= s4c_tsat;
      s4_sqf <= s4c_sq[53:0];
      s4_m2  <= s4c_m2;
      s4_m3  <= s4c_m3;
      s4_dz  <= s3_dz;
      s4_up  <= s3_up;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: B2 * (B6^2 >> 12) and B1 * (B6^2 >> 12).
  logic signed [42:0] s5c_sq;
  logic signed [58:0] s5_b2sq;
  logic signed [58:0] s5_b1sq;
  logic signed [43:0] s5_m2;
  logic signed [43:0] s5_m3;
  logic signed [15:0] s5_t;
  logic               s5_dz;
  logic [18:0]        s5_up;
  logic               s5_valid;

  assign s5c_sq = $signed({1'b0, s4_sqf[53:12]});

  always_ff @(posedge clk) begin
    if (en) begin
      s5_b2sq <= b2 * s5c_sq;
      s5_b1sq <= b1 * s5c_sq;
      s5_m2   <= s4_m2;
      s5_m3   <= s4_m3;
      s5_t    <= s4_t;
      s5_dz   <= s4_dz;
      s5_up   <= s4_up;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: AC1 * 4 + X3 for B3, and the second X3 for B4.
  logic signed [49:0] s6c_s;
  logic signed [44:0] s6c_xb;
  logic signed [49:0] s6_s;
  logic [31:0]        s6_x3lo;
  logic signed [15:0] s6_t;
  logic               s6_dz;
  logic [18:0]        s6_up;
  logic               s6_valid;

  assign s6c_s  = 50'($signed(s5_b2sq[58:11])) + 50'($signed(s5_m2[43:11]))
                + 50'($signed({ac1, 2'b00}));
  assign s6c_xb = 45'($signed(s5_m3[43:13])) + 45'($signed(s5_b1sq[58:16])) + 45'sd2;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_s    <= s6c_s;
      s6_x3lo <= s6c_xb[33:2];
      s6_t    <= s5_t;
      s6_dz   <= s5_dz;
      s6_up   <= s5_up;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: B3 (division by four toward zero) and the B4 product.
  logic signed [53:0] s7c_v;
  logic signed [53:0] s7c_vadj;
  logic [31:0]        s7c_x3b;
  logic [47:0]        s7c_b4f;
  logic [31:0]        s7_b3lo;
  logic [31:0]        s7_b4p;
  logic signed [15:0] s7_t;
  logic               s7_dz;
  logic [18:0]        s7_up;
  logic               s7_valid;

  assign s7c_v    = (54'(s6_s) <<< oversampling) + 54'sd2;
  assign s7c_vadj = s7c_v + (s7c_v[53] ? 54'sd3 : 54'sd0);
  assign s7c_x3b  = s6_x3lo + bpc_pkg::B4_BIAS;
  assign s7c_b4f  = ac4 * s7c_x3b;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_b3lo <= s7c_vadj[33:2];
      s7_b4p  <= s7c_b4f[31:0];
      s7_t    <= s6_t;
      s7_dz   <= s6_dz;
      s7_up   <= s6_up;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: B4 and B7, both modulo 2^32.
  logic [31:0]        s8c_diff;
  logic [15:0]        s8c_scale;
  logic [47:0]        s8c_b7f;
  logic [16:0]        s8c_b4;
  logic [16:0]        s8_b4;
  logic [31:0]        s8_b7;
  logic signed [15:0] s8_t;
  logic               s8_fault;
  logic               s8_valid;

  assign s8c_b4    = s7_b4p[31:15];
  assign s8c_diff  = 32'(s7_up) - s7_b3lo;
  assign s8c_scale = bpc_pkg::B7_SCALE >> oversampling;
  assign s8c_b7f   = s8c_diff * s8c_scale;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_b4    <= s8c_b4;
      s8_b7    <= s8c_b7f[31:0];
      s8_t     <= s7_t;
      s8_fault <= s7_dz || (s8c_b4 == 17'd0);
    end
  end

  // --------------------------------------------------------------------------
  // Pressure divider. A large B7 is divided as it is and the quotient doubled
  // afterwards; otherwise B7 is doubled before the division.
  logic                 pd_valid;
  logic [31:0]          pd_q;
  logic [PD_SIDE_W-1:0] pd_side;
  logic [31:0]          s8c_num;

  assign s8c_num = s8_b7[31] ? s8_b7 : {s8_b7[30:0], 1'b0};

  bpc_divider #(
    .NW (32),
    .DW (17),
    .SW (PD_SIDE_W)
  ) u_pdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s8_valid),
    .dividend  (s8c_num),
    .divisor   (s8_b4),
    .in_side   ({s8_t, s8_fault, s8_b7[31]}),
    .out_valid (pd_valid),
    .quotient  (pd_q),
    .out_side  (pd_side)
  );

  // --------------------------------------------------------------------------
  // Stage 9: raw pressure P, (P >> 8)^2 and P * -7357.
  logic signed [31:0] s9c_p;
  logic signed [23:0] s9c_pa;
  logic signed [47:0] s9c_sq;
  logic signed [45:0] s9c_m;
  logic [46:0]        s9_sqp;
  logic signed [45:0] s9_m;
  logic signed [31:0] s9_p;
  logic signed [15:0] s9_t;
  logic               s9_fault;
  logic               s9_valid;

  assign s9c_p  = $signed(pd_side[0] ? {pd_q[30:0], 1'b0} : pd_q);
  assign s9c_pa = $signed(s9c_p[31:8]);
  assign s9c_sq = s9c_pa * s9c_pa;
  assign s9c_m  = s9c_p * bpc_pkg::P_LIN_COEF;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_sqp   <= s9c_sq[46:0];
      s9_m     <= s9c_m;
      s9_p     <= s9c_p;
      s9_t     <= $signed(pd_side[17:2]);
      s9_fault <= pd_side[1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: square term times 3038.
  logic [58:0]        s10_m1;
  logic signed [45:0] s10_m;
  logic signed [31:0] s10_p;
  logic signed [15:0] s10_t;
  logic               s10_fault;
  logic               s10_valid;

  always_ff @(posedge clk) begin
    if (en) begin
      s10_m1    <= 59'(s9_sqp) * 59'(bpc_pkg::P_SQ_COEF);
      s10_m     <= s9_m;
      s10_p     <= s9_p;
      s10_t     <= s9_t;
      s10_fault <= s9_fault;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: final pressure sum, saturation and the output register.
  logic signed [45:0] oc_x1;
  logic signed [45:0] oc_x2;
  logic signed [45:0] oc_sum;
  logic signed [45:0] oc_p;
  logic [17:0]        oc_psat;

  assign oc_x1  = $signed({3'b000, s10_m1[58:16]});
  assign oc_x2  = 46'($signed(s10_m[45:16]));
  assign oc_sum = oc_x1 + oc_x2 + bpc_pkg::P_OFFSET;
  assign oc_p   = 46'(s10_p) + (oc_sum >>> 4);

  always_comb begin
    if (oc_p < 46'sd0) begin
      oc_psat = '0;
    end else if (oc_p > bpc_pkg::PRES_MAX) begin
      oc_psat = '1;
    end else begin
      oc_psat = oc_p[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temperature_tenths <= s10_fault ? 16'sd0 : s10_t;
      pressure_pa        <= s10_fault ? 18'd0 : oc_psat;
      fault              <= s10_fault;
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits of the pipeline stages outside the dividers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      s8_valid  <= 1'b0;
      s9_valid  <= 1'b0;
      s10_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= td_valid;
      s4_valid  <= s3_valid;
      s5_valid  <= s4_valid;
      s6_valid  <= s5_valid;
      s7_valid  <= s6_valid;
      s8_valid  <= s7_valid;
      s9_valid  <= pd_valid;
      s10_valid <= s9_valid;
      out_valid <= s10_valid;
    end
  end

`ifndef SYNTHESIS
  // A faulted word carries zero results.
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault) |-> (temperature_tenths == 16'sd0 && pressure_pa == 18'd0))
    else $error("faulted word with non-zero result");

  // A held output freezes the pipeline stages behind it.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> ($stable(s5_valid) && $stable(s9_valid) && $stable(s8_b7)))
    else $error("pipeline moved during a stall");

  // Nothing leaves the block straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A zero B4 is always flagged.
  a_b4_fault: assert property (@(posedge clk) disable iff (rst)
    (s8_valid && s8_b4 == 17'd0) |-> s8_fault)
    else $error("zero pressure divisor not flagged");
`endif

endmodule

`default_nettype wire
